// File: hdl/bounded_deque_with_dump_core_defines.svh
// assertion macros used by bdq_back
`ifndef BOUNDED_DEQUE_WITH_DUMP_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_DUMP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BDQ_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BDQ_ASSERT(lbl, prop, msg)
`define BDQ_NEVER(lbl, cond, msg)
`endif

`endif

// File: hdl/bdq_pkg.sv
package bdq_pkg;

    localparam int OPCODE_W      = 3;
    localparam int VALUE_W       = 32;
    localparam int DEPTH_DEFAULT = 64;
    localparam int CMDQ_DEPTH    = 2;
    localparam int RESQ_DEPTH    = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4
    } opcode_t;

    typedef struct packed {
        opcode_t                    op;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  entry_value;
        logic                       last;
        logic                       overflow;
    } res_t;

    typedef enum logic {
        BK_RUN,
        BK_DUMP
    } back_state_t;

endpackage

// File: hdl/bdq_fifo.sv
module bdq_fifo #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [W-1:0]             wr_data,
    output logic                     full,
    input  logic                     rd_en,
    output logic [W-1:0]             rd_data,
    output logic                     empty,
    output logic [$clog2(D+1)-1:0]   count
);

    localparam int AW = $clog2(D);
    localparam int CW = $clog2(D+1);

    logic [W-1:0]  slot_reg [D];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == CW'(D));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(D-1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(D-1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hdl/bdq_front.sv
module bdq_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [bdq_pkg::OPCODE_W-1:0]          opcode,
    input  logic signed [bdq_pkg::VALUE_W-1:0]    value,
    output logic                                  cmd_valid,
    output bdq_pkg::cmd_t                         cmd,
    input  logic                                  cmd_take
);

    import bdq_pkg::*;

    logic                        op_known;
    logic                        cmdq_empty;
    cmd_t                        cmd_in;
    logic [$bits(cmd_t)-1:0]     cmd_raw;
    logic [$clog2(CMDQ_DEPTH+1)-1:0] cmdq_count;

    // unused opcodes are consumed here and never reach the back end
    always_comb
    begin
        op_known     = (opcode inside {OP_PUSH_BACK, OP_PUSH_FRONT, OP_POP_FRONT,
                                       OP_POP_BACK, OP_DUMP});
        cmd_in.op    = opcode_t'(opcode);
        cmd_in.value = value;
    end

    bdq_fifo #(
        .W ($bits(cmd_t)),
        .D (CMDQ_DEPTH)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && op_known),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_take),
        .rd_data (cmd_raw),
        .empty   (cmdq_empty),
        .count   (cmdq_count)
    );

    assign cmd_valid = !cmdq_empty && (cmdq_count != '0);
    assign cmd       = cmd_t'(cmd_raw);

endmodule

// File: hdl/bdq_back.sv
`include "bounded_deque_with_dump_core_defines.svh"

module bdq_back #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  bdq_pkg::cmd_t     cmd,
    output logic              cmd_take,
    output logic              empty,
    input  logic              pop,
    output bdq_pkg::res_t     res
);

    import bdq_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH+1);
    localparam int QCW = $clog2(RESQ_DEPTH+1);

    logic [VALUE_W-1:0] mem [DEPTH];

    back_state_t   state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          stg_valid_reg, stg_valid_next;
    logic          stg_last_reg, stg_last_next;
    logic          stg_ovf_reg, stg_ovf_next;
    logic [VALUE_W-1:0] rd_data_reg;

    logic          is_full, is_empty, room, dump_last;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW:0]   back_sum, dump_sum, next_sum;
    logic [AW-1:0] back_slot, dump_slot, next_slot, prev_slot;
    logic [QCW:0]  resq_used;
    logic [QCW-1:0] resq_count;
    logic          resq_full;
    res_t          res_in;
    logic [$bits(res_t)-1:0] res_raw;

    // ring index arithmetic, both operands below DEPTH
    always_comb
    begin
        back_sum  = {1'b0, front_reg} + {1'b0, count_reg[AW-1:0]};
        dump_sum  = {1'b0, front_reg} + {1'b0, idx_reg};
        next_sum  = {1'b0, front_reg} + (AW+1)'(1);
        back_slot = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                 : back_sum[AW-1:0];
        dump_slot = (dump_sum >= (AW+1)'(DEPTH)) ? AW'(dump_sum - (AW+1)'(DEPTH))
                                                 : dump_sum[AW-1:0];
        next_slot = (next_sum >= (AW+1)'(DEPTH)) ? '0 : next_sum[AW-1:0];
        prev_slot = (front_reg == '0) ? AW'(DEPTH-1) : front_reg - AW'(1);
    end

    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign resq_used = {1'b0, resq_count} + (QCW+1)'(stg_valid_reg);
    assign room      = (resq_used < (QCW+1)'(RESQ_DEPTH));
    assign dump_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN:
            begin
                if (cmd_valid && cmd.op == OP_DUMP && !is_empty)
                begin
                    state_next = BK_DUMP;
                end
            end
            BK_DUMP:
            begin
                if (room && dump_last)
                begin
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        cmd_take       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = back_slot;
        front_next     = front_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        stg_valid_next = 1'b0;
        stg_last_next  = 1'b0;
        stg_ovf_next   = 1'b0;
        case (state_reg)
            BK_RUN:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_PUSH_BACK, OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                if (room)
                                begin
                                    cmd_take       = 1'b1;
                                    stg_valid_next = 1'b1;
                                    stg_last_next  = 1'b1;
                                    stg_ovf_next   = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd_take   = 1'b1;
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (cmd.op == OP_PUSH_FRONT)
                                begin
                                    mem_waddr  = prev_slot;
                                    front_next = prev_slot;
                                end
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            cmd_take = 1'b1;
                            if (!is_empty)
                            begin
                                front_next = next_slot;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_POP_BACK:
                        begin
                            cmd_take = 1'b1;
                            if (!is_empty)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_DUMP:
                        begin
                            cmd_take = 1'b1;
                            idx_next = '0;
                        end
                        default:
                        begin
                            cmd_take = 1'b1;
                        end
                    endcase
                end
            end
            BK_DUMP:
            begin
                if (room)
                begin
                    stg_valid_next = 1'b1;
                    stg_last_next  = dump_last;
                    idx_next       = idx_reg + AW'(1);
                end
            end
            default:
            begin
                cmd_take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_last_reg <= stg_last_next;
        stg_ovf_reg  <= stg_ovf_next;
        rd_data_reg  <= mem[dump_slot];
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd.value;
        end
    end

    always_comb
    begin
        res_in.entry_value = stg_ovf_reg ? '0 : rd_data_reg;
        res_in.last        = stg_last_reg;
        res_in.overflow    = stg_ovf_reg;
    end

    bdq_fifo #(
        .W ($bits(res_t)),
        .D (RESQ_DEPTH)
    ) u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (stg_valid_reg),
        .wr_data (res_in),
        .full    (resq_full),
        .rd_en   (pop),
        .rd_data (res_raw),
        .empty   (empty),
        .count   (resq_count)
    );

    assign res = res_t'(res_raw);

    `BDQ_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "fill count above depth")
    `BDQ_NEVER(a_resq_overrun, stg_valid_reg && resq_full, "result queue overrun")
    `BDQ_ASSERT(a_dump_nonempty, state_reg == BK_DUMP |-> count_reg != '0, "dump of empty ring")
    `BDQ_ASSERT(a_ovf_when_full, stg_valid_reg && stg_ovf_reg |-> $past(is_full), "overflow not full")

endmodule

// File: hdl/bounded_deque_with_dump_core.sv
// Double-ended queue of signed 32-bit values in a ring of DEPTH entries. Items enter
// through a two-entry command queue; push back, push front, pop front and pop back are
// sustained at one item per cycle while no dump runs. A dump streams the stored values
// from front to back at one per cycle, limited by the single read port of the ring
// memory; each read passes through the read data and staging registers into the result
// queue. A push to a full ring is dropped and yields one result with overflow and last
// set. Pops of an empty ring, dumps of an empty ring and unused opcodes produce no
// result. Results wait in a four-entry queue; while it is full, counting a staged
// result, dumps and pushes to a full ring stall.
module bounded_deque_with_dump_core #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [bdq_pkg::OPCODE_W-1:0]          opcode,
    input  logic signed [bdq_pkg::VALUE_W-1:0]    value,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [bdq_pkg::VALUE_W-1:0]    entry_value,
    output logic                                  last,
    output logic                                  overflow
);

    import bdq_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;
    res_t res;

    bdq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    bdq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign entry_value = res.entry_value;
    assign last        = res.last;
    assign overflow    = res.overflow;

endmodule
